FILE: hdl/pcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types, codes and the class color table for the point color mapper.
// ----------------------------------------------------------------------------
package pcm_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Per-point control that rides along the divider chain.
    typedef struct packed {
        logic ramp;    // height ramp selected, color comes from the quotient
        logic sat_lo;  // ramp position forced to 0 (empty or inverted bounds, or at or below min)
        logic sat_hi;  // ramp position forced to 1 (at or above max)
        t_rgb rgb;     // final color when ramp is clear
    } t_tag;

    // Color scheme codes.
    localparam logic [2:0] SCH_OWN       = 3'd0;
    localparam logic [2:0] SCH_HEIGHT    = 3'd1;
    localparam logic [2:0] SCH_INTENSITY = 3'd2;
    localparam logic [2:0] SCH_CLASS     = 3'd3;
    localparam logic [2:0] SCH_NORMAL    = 3'd4;

    // Register indexes of the write port.
    localparam logic [2:0] REG_USE_POINT_COLOR  = 3'd0;
    localparam logic [2:0] REG_CLOUD_HAS_COLORS = 3'd1;
    localparam logic [2:0] REG_USE_COLOR_MAP    = 3'd2;
    localparam logic [2:0] REG_COLOR_SCHEME     = 3'd3;
    localparam logic [2:0] REG_HEIGHT_MIN       = 3'd4;
    localparam logic [2:0] REG_HEIGHT_MAX       = 3'd5;
    localparam logic [2:0] REG_DEFAULT_RGB      = 3'd6;

    localparam logic [23:0] DEFAULT_RGB_RST = 24'hFF_FFFF;

    // LAS classification colors; unknown codes are white.
    function automatic t_rgb class_color(input logic [7:0] code);
        t_rgb c;
        begin
            case (code)
                8'd0:    c = '{8'd0,   8'd0,   8'd0};
                8'd1:    c = '{8'd128, 8'd128, 8'd128};
                8'd2:    c = '{8'd139, 8'd69,  8'd19};
                8'd3:    c = '{8'd0,   8'd128, 8'd0};
                8'd4:    c = '{8'd0,   8'd200, 8'd0};
                8'd5:    c = '{8'd0,   8'd255, 8'd0};
                8'd6:    c = '{8'd255, 8'd0,   8'd0};
                8'd7:    c = '{8'd128, 8'd0,   8'd255};
                8'd9:    c = '{8'd0,   8'd0,   8'd255};
                8'd17:   c = '{8'd255, 8'd255, 8'd0};
                default: c = '{8'd255, 8'd255, 8'd255};
            endcase
            return c;
        end
    endfunction

endpackage

FILE: hdl/pcm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_cell
// One restoring-division step: shift remainder, trial subtract, one quotient bit.
// ----------------------------------------------------------------------------
module pcm_cell #(
    parameter int REM_W  = 33,
    parameter int QUO_W  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [REM_W-1:0]     i_rem,
    input  logic [REM_W-1:0]     i_div,
    input  logic [QUO_W-1:0]     i_quo,
    input  pcm_pkg::t_tag        i_tag,
    output logic                 o_valid,
    output logic [REM_W-1:0]     o_rem,
    output logic [REM_W-1:0]     o_div,
    output logic [QUO_W-1:0]     o_quo,
    output pcm_pkg::t_tag        o_tag
);

    logic [REM_W:0]   w_shift;
    logic [REM_W:0]   w_trial;
    logic             w_bit;
    logic [REM_W-1:0] n_rem;

    assign w_shift = {i_rem, 1'b0};
    assign w_trial = w_shift - {1'b0, i_div};
    assign w_bit   = (w_shift >= {1'b0, i_div});
    assign n_rem   = w_bit ? w_trial[REM_W-1:0] : w_shift[REM_W-1:0];

    logic                 r_valid;
    logic [REM_W-1:0]     r_rem;
    logic [REM_W-1:0]     r_div;
    logic [QUO_W-1:0]     r_quo;
    pcm_pkg::t_tag        r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= i_div;
        r_quo <= {i_quo[QUO_W-2:0], w_bit};
        r_tag <= i_tag;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quo   = r_quo;
    assign o_tag   = r_tag;

endmodule

FILE: hdl/pcm_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_ramp
// Output stage: blue-green-yellow-red ramp from the quotient, final color reg.
// ----------------------------------------------------------------------------
module pcm_ramp #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [FRACTION_BITS-1:0] i_quo,
    input  pcm_pkg::t_tag            i_tag,
    output logic                     o_valid,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue
);

    localparam int FB = FRACTION_BITS;
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    logic [FB:0]   w_n;      // ramp position, 1.0 = ONE
    logic [1:0]    w_seg;
    logic [FB:0]   w_v;      // 4 * (n - segment base)
    logic [FB:0]   w_w;      // 1 - v
    logic [FB+8:0] w_up_p;
    logic [FB+8:0] w_dn_p;
    logic [7:0]    w_up;
    logic [7:0]    w_dn;
    pcm_pkg::t_rgb w_ramp;
    pcm_pkg::t_rgb n_rgb;

    always_comb begin
        if (i_tag.sat_lo) begin
            w_n = '0;
        end else if (i_tag.sat_hi) begin
            w_n = ONE;
        end else begin
            w_n = {1'b0, i_quo};
        end
        w_seg  = w_n[FB] ? 2'd3 : w_n[FB-1:FB-2];
        w_v    = w_n[FB] ? ONE : {1'b0, w_n[FB-3:0], 2'b00};
        w_w    = ONE - w_v;
        // x * 255 as (x << 8) - x
        w_up_p = {w_v, 8'd0} - {8'd0, w_v};
        w_dn_p = {w_w, 8'd0} - {8'd0, w_w};
        w_up   = w_up_p[FB+7:FB];
        w_dn   = w_dn_p[FB+7:FB];
        case (w_seg)
            2'd0:    w_ramp = '{w_up,  w_up,  8'd255};
            2'd1:    w_ramp = '{w_up,  8'd255, w_dn};
            2'd2:    w_ramp = '{8'd255, 8'd255, w_up};
            default: w_ramp = '{8'd255, w_dn,  w_dn};
        endcase
        n_rgb = i_tag.ramp ? w_ramp : i_tag.rgb;
    end

    logic          r_valid;
    pcm_pkg::t_rgb r_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb <= n_rgb;
    end

    assign o_valid = r_valid;
    assign o_red   = r_rgb.red;
    assign o_green = r_rgb.green;
    assign o_blue  = r_rgb.blue;

endmodule

FILE: hdl/point_color_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_color_mapper_core
// Per-point RGB selection: own color, height ramp, gray, class, normal map or default.
// ----------------------------------------------------------------------------
// Usage
//   Input: a point transfer happens on a rising edge with start high and busy
//   low. busy is always low, so a point may be offered on every cycle.
//   Output: each point yields one color, shown on o_red/o_green/o_blue for
//   exactly one cycle with o_valid high. The receiver cannot stall; points
//   leave in the order they came in.
//   Pipeline: stage A, stage B, then the height divider with one cell per
//   quotient bit in a row, then the output register. Throughput: one point
//   per cycle.
//   Configuration: plain write port (i_cfg_we, i_cfg_idx, i_cfg_wdata), one
//   register per write, no read-back. Change registers only while no point
//   is in flight. Index 7 is ignored.
//   Reset (synchronous, active low): registers go to their defaults
//   (point colors preferred, no colors in cloud, map off, scheme 0, bounds 0,
//   default white) and the pipeline is emptied; in-flight points are lost.
// ----------------------------------------------------------------------------
module point_color_mapper_core #(
    parameter int HEIGHT_BITS   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // point input
    input  logic                          start,
    output logic                          busy,
    input  logic signed [HEIGHT_BITS-1:0] i_height,
    input  logic [16:0]                   i_intensity,
    input  logic [7:0]                    i_class_code,
    input  logic signed [15:0]            i_normal_x,
    input  logic signed [15:0]            i_normal_y,
    input  logic signed [15:0]            i_normal_z,
    input  logic [7:0]                    i_own_red,
    input  logic [7:0]                    i_own_green,
    input  logic [7:0]                    i_own_blue,
    // color output
    output logic                          o_valid,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [((HEIGHT_BITS > 24) ? HEIGHT_BITS : 24)-1:0] i_cfg_wdata
);

    localparam int HB    = HEIGHT_BITS;
    localparam int FB    = FRACTION_BITS;
    localparam int REM_W = HB + 1;   // signed difference of two heights

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic          r_use_point_color;
    logic          r_cloud_has_colors;
    logic          r_use_color_map;
    logic [2:0]    r_color_scheme;
    logic [HB-1:0] r_height_min;
    logic [HB-1:0] r_height_max;
    logic [23:0]   r_default_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_point_color  <= 1'b1;
            r_cloud_has_colors <= 1'b0;
            r_use_color_map    <= 1'b0;
            r_color_scheme     <= pcm_pkg::SCH_OWN;
            r_height_min       <= '0;
            r_height_max       <= '0;
            r_default_rgb      <= pcm_pkg::DEFAULT_RGB_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcm_pkg::REG_USE_POINT_COLOR:  r_use_point_color  <= i_cfg_wdata[0];
                pcm_pkg::REG_CLOUD_HAS_COLORS: r_cloud_has_colors <= i_cfg_wdata[0];
                pcm_pkg::REG_USE_COLOR_MAP:    r_use_color_map    <= i_cfg_wdata[0];
                pcm_pkg::REG_COLOR_SCHEME:     r_color_scheme     <= i_cfg_wdata[2:0];
                pcm_pkg::REG_HEIGHT_MIN:       r_height_min       <= i_cfg_wdata[HB-1:0];
                pcm_pkg::REG_HEIGHT_MAX:       r_height_max       <= i_cfg_wdata[HB-1:0];
                pcm_pkg::REG_DEFAULT_RGB:      r_default_rgb      <= i_cfg_wdata[23:0];
                default: ;  // no register at this index
            endcase
        end
    end

    // The pipeline never pushes back.
    assign busy = 1'b0;

    logic w_accept;
    assign w_accept = start && !busy;

    // ------------------------------------------------------------------
    // Stage A: every non-height color is finished here; height gets its
    // two differences.
    // ------------------------------------------------------------------

    // Q14 normal component -> floor((c + 1.0) * 255 / 2.0), clamped to a byte.
    function automatic logic [7:0] normal_chan(input logic [15:0] c);
        logic signed [16:0] s;
        logic [15:0]        u;
        logic [23:0]        p;
        logic [8:0]         v;
        logic [7:0]         res;
        begin
            s = $signed({c[15], c}) + 17'sd16384;
            u = s[15:0];
            p = {u, 8'd0} - {8'd0, u};
            v = p[23:15];
            if (s <= 17'sd0) begin
                res = 8'd0;
            end else if (v > 9'd255) begin
                res = 8'd255;
            end else begin
                res = v[7:0];
            end
            return res;
        end
    endfunction

    logic [24:0]   w_gray_p;
    logic [8:0]    w_gray_v;
    logic [7:0]    w_gray;
    pcm_pkg::t_rgb w_own;
    pcm_pkg::t_tag n_a_tag;

    always_comb begin
        // intensity * 255 >> 16, saturated
        w_gray_p = {i_intensity, 8'd0} - {8'd0, i_intensity};
        w_gray_v = w_gray_p[24:16];
        w_gray   = (w_gray_v > 9'd255) ? 8'd255 : w_gray_v[7:0];
        w_own    = '{i_own_red, i_own_green, i_own_blue};

        n_a_tag        = '0;
        n_a_tag.rgb    = r_default_rgb;
        if (r_use_point_color && r_cloud_has_colors) begin
            n_a_tag.rgb = w_own;
        end else if (r_use_color_map) begin
            unique case (r_color_scheme)
                pcm_pkg::SCH_OWN:       n_a_tag.rgb  = w_own;
                pcm_pkg::SCH_HEIGHT:    n_a_tag.ramp = 1'b1;
                pcm_pkg::SCH_INTENSITY: n_a_tag.rgb  = '{w_gray, w_gray, w_gray};
                pcm_pkg::SCH_CLASS:     n_a_tag.rgb  = pcm_pkg::class_color(i_class_code);
                pcm_pkg::SCH_NORMAL: begin
                    n_a_tag.rgb = '{normal_chan(i_normal_x),
                                    normal_chan(i_normal_y),
                                    normal_chan(i_normal_z)};
                end
                default: ;  // unused codes keep the default color
            endcase
        end
    end

    logic             r_a_valid;
    logic [REM_W-1:0] r_a_diff;    // height - min
    logic [REM_W-1:0] r_a_range;   // max - min
    pcm_pkg::t_tag    r_a_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_diff  <= {i_height[HB-1], i_height} - {r_height_min[HB-1], r_height_min};
        r_a_range <= {r_height_max[HB-1], r_height_max} - {r_height_min[HB-1], r_height_min};
        r_a_tag   <= n_a_tag;
    end

    // ------------------------------------------------------------------
    // Stage B: clamp decisions. Empty or inverted bounds, or a point at or
    // below min, sit at the blue end; at or above max, at the red end.
    // Only strictly inside points use the quotient.
    // ------------------------------------------------------------------
    logic          w_range_le0;
    logic          w_diff_le0;
    logic          w_diff_ge;
    pcm_pkg::t_tag n_b_tag;

    always_comb begin
        w_range_le0    = r_a_range[REM_W-1] || (r_a_range == '0);
        w_diff_le0     = r_a_diff[REM_W-1] || (r_a_diff == '0);
        w_diff_ge      = ($signed(r_a_diff) >= $signed(r_a_range));
        n_b_tag        = r_a_tag;
        n_b_tag.sat_lo = w_range_le0 || w_diff_le0;
        n_b_tag.sat_hi = w_diff_ge;
    end

    logic             r_b_valid;
    logic [REM_W-1:0] r_b_diff;
    logic [REM_W-1:0] r_b_range;
    pcm_pkg::t_tag    r_b_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_diff  <= r_a_diff;
        r_b_range <= r_a_range;
        r_b_tag   <= n_b_tag;
    end

    // ------------------------------------------------------------------
    // Divider chain: one cell per quotient bit, MSB first. Inside points
    // satisfy 0 < diff < range, so the remainder stays below the divisor.
    // ------------------------------------------------------------------
    logic                 w_valid [0:FB];
    logic [REM_W-1:0]     w_rem   [0:FB];
    logic [REM_W-1:0]     w_div   [0:FB];
    logic [FB-1:0]        w_quo   [0:FB];
    pcm_pkg::t_tag        w_tag   [0:FB];

    assign w_valid[0] = r_b_valid;
    assign w_rem[0]   = r_b_diff;
    assign w_div[0]   = r_b_range;
    assign w_quo[0]   = '0;
    assign w_tag[0]   = r_b_tag;

    for (genvar g = 0; g < FB; g++) begin : g_cell
        pcm_cell #(
            .REM_W (REM_W),
            .QUO_W (FB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_div   (w_div[g]),
            .i_quo   (w_quo[g]),
            .i_tag   (w_tag[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_div   (w_div[g+1]),
            .o_quo   (w_quo[g+1]),
            .o_tag   (w_tag[g+1])
        );
    end

    // Final remainder and divisor are not needed past the last cell.
    logic w_unused_tail;
    assign w_unused_tail = ^{w_rem[FB], w_div[FB]};

    // ------------------------------------------------------------------
    // Output stage: ramp color and result register.
    // ------------------------------------------------------------------
    pcm_ramp #(
        .FRACTION_BITS (FB)
    ) u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[FB] && (w_unused_tail || !w_unused_tail)),
        .i_quo   (w_quo[FB]),
        .i_tag   (w_tag[FB]),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

FILE: hdl/pcm_core_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_core_chk
// Port-level checks on the point color mapper, bound to the top level.
// ----------------------------------------------------------------------------
module pcm_core_chk #(
    parameter int HEIGHT_BITS   = 32,
    parameter int FRACTION_BITS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    localparam int LAT = FRACTION_BITS + 3;
    localparam int HB_USED = HEIGHT_BITS;

    // Every input transfer is followed by a result strobe.
    a_xfer_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("input transfer without result after %0d cycles", LAT);

    // No result without a matching input transfer.
    a_result_from_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n && (HB_USED > 0), LAT))
        else $error("result without input transfer");

    // Reset empties the pipeline.
    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

    // The mapper never refuses a point.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> !busy)
        else $error("busy raised");

endmodule

bind point_color_mapper_core pcm_core_chk #(
    .HEIGHT_BITS   (HEIGHT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_pcm_core_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

FILE: tb/sv/tb_point_color_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_color_mapper_core
// Self-checking bench for the point color mapper. A local predictor computes
// the color of every accepted point from the current register values, and a
// monitor compares each output strobe against the oldest pending color.
// Directed tests cover own color, ramp thresholds and bounds, gray
// saturation, class codes, normal clamping and the spare schemes. A random
// pass then runs many register settings, with or without random feed gaps.
// ----------------------------------------------------------------------------
module tb_point_color_mapper_core;

    localparam int FRAC_BITS   = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = FRAC_BITS + 8;  // > pipeline depth

    localparam logic [63:0] RAMP_ONE     = 64'd1 << FRAC_BITS;
    localparam logic [63:0] RAMP_QUARTER = RAMP_ONE >> 2;

    // Index past the register list; writes must be dropped.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Scheme codes with no mapping of their own (default color).
    localparam logic [2:0] SCH_SPARE_FIRST = 3'd5;
    localparam logic [2:0] SCH_SPARE_LAST  = 3'd7;

    // LAS class codes that have a table color, plus one that does not.
    localparam logic [7:0] CLS_NEVER_CLASSIFIED = 8'd0;
    localparam logic [7:0] CLS_GROUND           = 8'd2;
    localparam logic [7:0] CLS_LOW_POINT        = 8'd7;
    localparam logic [7:0] CLS_KEY_POINT        = 8'd8;
    localparam logic [7:0] CLS_WATER            = 8'd9;
    localparam logic [7:0] CLS_BRIDGE_DECK      = 8'd17;

    typedef struct {
        logic                use_point_color;
        logic                cloud_has_colors;
        logic                use_color_map;
        logic [2:0]          scheme;
        logic signed [31:0]  height_min;
        logic signed [31:0]  height_max;
        logic [23:0]         default_rgb;
    } t_map_cfg;

    typedef struct {
        logic signed [31:0]  height;
        logic [16:0]         intensity;
        logic [7:0]          class_code;
        logic signed [15:0]  normal_x;
        logic signed [15:0]  normal_y;
        logic signed [15:0]  normal_z;
        logic [7:0]          own_red;
        logic [7:0]          own_green;
        logic [7:0]          own_blue;
    } t_point;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_height;
    logic [16:0]        i_intensity;
    logic [7:0]         i_class_code;
    logic signed [15:0] i_normal_x;
    logic signed [15:0] i_normal_y;
    logic signed [15:0] i_normal_z;
    logic [7:0]         i_own_red;
    logic [7:0]         i_own_green;
    logic [7:0]         i_own_blue;
    logic               o_valid;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_wdata;

    point_color_mapper_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_height     (i_height),
        .i_intensity  (i_intensity),
        .i_class_code (i_class_code),
        .i_normal_x   (i_normal_x),
        .i_normal_y   (i_normal_y),
        .i_normal_z   (i_normal_z),
        .i_own_red    (i_own_red),
        .i_own_green  (i_own_green),
        .i_own_blue   (i_own_blue),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_map_cfg      map_cfg;          // register values as the DUT should hold them
    pcm_pkg::t_rgb pending_colors[$];
    pcm_pkg::t_rgb want_color;
    int            n_points;
    int            n_colors;
    int            n_settings;
    int            n_mismatch;
    int            cycle_count;
    bit            steady_feed;      // no input gaps while set

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Color predictor
    // ------------------------------------------------------------------------

    // Blue-green-yellow-red ramp. Position is an exact restoring quotient,
    // clamped to [0, 1]; empty or inverted bounds give position 0 (blue).
    function automatic pcm_pkg::t_rgb ramp_color(t_map_cfg c, logic signed [31:0] h);
        logic signed [63:0] span_w;
        logic signed [63:0] diff;
        logic [63:0]        rem;
        logic [63:0]        n;
        logic [63:0]        base;
        logic [63:0]        v;
        logic [63:0]        up;
        logic [63:0]        down;
        pcm_pkg::t_rgb      col;
        span_w = 64'(c.height_max) - 64'(c.height_min);
        diff   = 64'(h) - 64'(c.height_min);
        if (span_w <= 0 || diff <= 0) begin
            n = '0;
        end else if (diff >= span_w) begin
            n = RAMP_ONE;
        end else begin
            rem = diff;
            n   = '0;
            for (int i = 0; i < FRAC_BITS; i++) begin
                rem = rem << 1;
                n   = n << 1;
                if (rem >= 64'(span_w)) begin
                    rem  = rem - 64'(span_w);
                    n[0] = 1'b1;
                end
            end
        end
        if (n < RAMP_QUARTER)
            base = '0;
        else if (n < 2 * RAMP_QUARTER)
            base = RAMP_QUARTER;
        else if (n < 3 * RAMP_QUARTER)
            base = 2 * RAMP_QUARTER;
        else
            base = 3 * RAMP_QUARTER;
        v    = (n - base) * 4;
        up   = (v * 255) >> FRAC_BITS;
        down = ((RAMP_ONE - v) * 255) >> FRAC_BITS;
        if (n < RAMP_QUARTER)
            col = '{up[7:0], up[7:0], 8'd255};
        else if (n < 2 * RAMP_QUARTER)
            col = '{up[7:0], 8'd255, down[7:0]};
        else if (n < 3 * RAMP_QUARTER)
            col = '{8'd255, 8'd255, up[7:0]};
        else
            col = '{8'd255, down[7:0], down[7:0]};
        return col;
    endfunction

    // Q14 component mapped from [-1, 1] to [0, 255], clamped both ways.
    function automatic logic [7:0] normal_level(logic signed [15:0] comp);
        logic signed [31:0] shifted;
        logic [31:0]        lvl;
        shifted = 32'(comp) + 32'sd16384;
        if (shifted <= 0)
            return 8'd0;
        lvl = 32'(shifted);
        lvl = (lvl * 255) >> 15;
        return (lvl > 255) ? 8'd255 : lvl[7:0];
    endfunction

    function automatic pcm_pkg::t_rgb class_lut(logic [7:0] code);
        case (code)
            CLS_NEVER_CLASSIFIED: return '{8'd0,   8'd0,   8'd0};
            8'd1:                 return '{8'd128, 8'd128, 8'd128};
            CLS_GROUND:           return '{8'd139, 8'd69,  8'd19};
            8'd3:                 return '{8'd0,   8'd128, 8'd0};
            8'd4:                 return '{8'd0,   8'd200, 8'd0};
            8'd5:                 return '{8'd0,   8'd255, 8'd0};
            8'd6:                 return '{8'd255, 8'd0,   8'd0};
            CLS_LOW_POINT:        return '{8'd128, 8'd0,   8'd255};
            CLS_WATER:            return '{8'd0,   8'd0,   8'd255};
            CLS_BRIDGE_DECK:      return '{8'd255, 8'd255, 8'd0};
            default:              return '{8'd255, 8'd255, 8'd255};
        endcase
    endfunction

    function automatic pcm_pkg::t_rgb color_of(t_map_cfg c, t_point p);
        pcm_pkg::t_rgb col;
        pcm_pkg::t_rgb own;
        logic [31:0]   gray;
        own = '{p.own_red, p.own_green, p.own_blue};
        col = pcm_pkg::t_rgb'(c.default_rgb);
        if (c.use_point_color && c.cloud_has_colors) begin
            col = own;
        end else if (c.use_color_map) begin
            case (c.scheme)
                pcm_pkg::SCH_OWN:       col = own;
                pcm_pkg::SCH_HEIGHT:    col = ramp_color(c, p.height);
                pcm_pkg::SCH_INTENSITY: begin
                    gray = ({15'd0, p.intensity} * 255) >> 16;
                    if (gray > 255)
                        gray = 255;
                    col = '{gray[7:0], gray[7:0], gray[7:0]};
                end
                pcm_pkg::SCH_CLASS:     col = class_lut(p.class_code);
                pcm_pkg::SCH_NORMAL:    col = '{normal_level(p.normal_x),
                                                normal_level(p.normal_y),
                                                normal_level(p.normal_z)};
                default:       ;
            endcase
        end
        return col;
    endfunction

    // ------------------------------------------------------------------------
    // Result monitor: every strobe must match the oldest pending color.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, pcm_pkg::t_rgb want_c,
                                   pcm_pkg::t_rgb got_c);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("%0t: %s: expected rgb %02h %02h %02h, got %02h %02h %02h",
                     $realtime, what, want_c.red, want_c.green, want_c.blue,
                     got_c.red, got_c.green, got_c.blue);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_colors++;
            if (pending_colors.size() == 0) begin
                report_mismatch("color with nothing pending", '0,
                                '{o_red, o_green, o_blue});
            end else begin
                want_color = pending_colors.pop_front();
                if (o_red !== want_color.red || o_green !== want_color.green ||
                    o_blue !== want_color.blue)
                    report_mismatch("color mismatch", want_color,
                                    '{o_red, o_green, o_blue});
            end
        end
    end

    // Hard stop in case the DUT hangs or drops results.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d colors still pending",
                     cycle_count, pending_colors.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One point transfer. start stays high into the next call when that call
    // draws no gap, so it is never dropped and raised in the same step.
    task automatic send_point(input t_point p);
        int gap;
        gap = steady_feed ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_height     <= p.height;
        i_intensity  <= p.intensity;
        i_class_code <= p.class_code;
        i_normal_x   <= p.normal_x;
        i_normal_y   <= p.normal_y;
        i_normal_z   <= p.normal_z;
        i_own_red    <= p.own_red;
        i_own_green  <= p.own_green;
        i_own_blue   <= p.own_blue;
        do
            @(posedge i_clk);
        while (busy);
        pending_colors.push_back(color_of(map_cfg, p));
        n_points++;
    endtask

    // Stop feeding and wait for the pipeline to empty.
    task automatic settle();
        start <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Unused upper data bits carry noise; the DUT must mask them.
    task automatic apply_cfg(input t_map_cfg c);
        settle();
        write_reg(pcm_pkg::REG_USE_POINT_COLOR,  {31'($urandom), c.use_point_color});
        write_reg(pcm_pkg::REG_CLOUD_HAS_COLORS, {31'($urandom), c.cloud_has_colors});
        write_reg(pcm_pkg::REG_USE_COLOR_MAP,    {31'($urandom), c.use_color_map});
        write_reg(pcm_pkg::REG_COLOR_SCHEME,     {29'($urandom), c.scheme});
        write_reg(pcm_pkg::REG_HEIGHT_MIN,       32'(c.height_min));
        write_reg(pcm_pkg::REG_HEIGHT_MAX,       32'(c.height_max));
        write_reg(pcm_pkg::REG_DEFAULT_RGB,      {8'($urandom), c.default_rgb});
        write_reg(REG_UNUSED,                    $urandom);
        i_cfg_we <= 1'b0;
        map_cfg = c;
        n_settings++;
    endtask

    function automatic t_point random_point();
        t_point p;
        p.height     = $urandom;
        p.intensity  = 17'($urandom_range(0, 131071));
        p.class_code = 8'($urandom);
        p.normal_x   = 16'($urandom);
        p.normal_y   = 16'($urandom);
        p.normal_z   = 16'($urandom);
        p.own_red    = 8'($urandom);
        p.own_green  = 8'($urandom);
        p.own_blue   = 8'($urandom);
        return p;
    endfunction

    // Color map on, point colors off, given scheme.
    function automatic t_map_cfg scheme_cfg(input logic [2:0] s);
        t_map_cfg c;
        c = map_cfg;
        c.use_point_color  = 1'b0;
        c.cloud_has_colors = 1'b1;
        c.use_color_map    = 1'b1;
        c.scheme           = s;
        return c;
    endfunction

    task automatic send_height(input logic signed [31:0] h);
        t_point p;
        p = random_point();
        p.height = h;
        send_point(p);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: map off and no cloud colors, so the default white.
    task automatic test_after_reset();
        send_point(random_point());
    endtask

    task automatic test_own_color();
        t_map_cfg c;
        t_point   p;
        c = map_cfg;
        c.use_point_color  = 1'b1;
        c.cloud_has_colors = 1'b1;
        apply_cfg(c);
        p = random_point();
        p.own_red = 8'h00; p.own_green = 8'h00; p.own_blue = 8'h00;
        send_point(p);
        p = random_point();
        p.own_red = 8'hFF; p.own_green = 8'hFF; p.own_blue = 8'hFF;
        send_point(p);
        // own color through the scheme select
        apply_cfg(scheme_cfg(pcm_pkg::SCH_OWN));
        send_point(random_point());
    endtask

    task automatic test_height_ramp();
        t_map_cfg c;
        c = scheme_cfg(pcm_pkg::SCH_HEIGHT);
        // quarter steps of a 0..4000 span, plus both sides of the bounds
        c.height_min = 32'sd0;
        c.height_max = 32'sd4000;
        apply_cfg(c);
        send_height(-32'sd1);
        send_height(32'sd999);
        send_height(32'sd1000);
        send_height(32'sd2000);
        send_height(32'sd3000);
        send_height(32'sd4000);
        // full signed span
        c.height_min = 32'sh8000_0000;
        c.height_max = 32'sh7FFF_FFFF;
        apply_cfg(c);
        send_height(32'sh8000_0000);
        send_height(32'sh7FFF_FFFF);
        // empty bounds, then inverted bounds: both blue
        c.height_min = 32'sd123;
        c.height_max = 32'sd123;
        apply_cfg(c);
        send_height(32'sd123);
        c.height_min = 32'sd500;
        c.height_max = -32'sd500;
        apply_cfg(c);
        send_height(32'sd0);
    endtask

    task automatic test_intensity_gray();
        t_point p;
        apply_cfg(scheme_cfg(pcm_pkg::SCH_INTENSITY));
        p = random_point(); p.intensity = 17'd0;      send_point(p);
        p = random_point(); p.intensity = 17'd65536;  send_point(p);
        p = random_point(); p.intensity = 17'd131071; send_point(p);
    endtask

    task automatic test_class_table();
        t_point p;
        apply_cfg(scheme_cfg(pcm_pkg::SCH_CLASS));
        p = random_point(); p.class_code = CLS_NEVER_CLASSIFIED; send_point(p);
        p = random_point(); p.class_code = CLS_GROUND;           send_point(p);
        p = random_point(); p.class_code = CLS_KEY_POINT;        send_point(p);
        p = random_point(); p.class_code = CLS_WATER;            send_point(p);
        p = random_point(); p.class_code = CLS_BRIDGE_DECK;      send_point(p);
        p = random_point(); p.class_code = 8'hFF;                send_point(p);
    endtask

    // Both in-range ends and both clamp directions.
    task automatic test_normal_map();
        t_point p;
        apply_cfg(scheme_cfg(pcm_pkg::SCH_NORMAL));
        p = random_point();
        p.normal_x = 16'sh8000; p.normal_y = 16'sd16384; p.normal_z = 16'sd0;
        send_point(p);
        p = random_point();
        p.normal_x = 16'sh7FFF; p.normal_y = -16'sd16384; p.normal_z = -16'sd16383;
        send_point(p);
    endtask

    task automatic test_default_color();
        t_map_cfg c;
        c = scheme_cfg(SCH_SPARE_FIRST);
        c.default_rgb = 24'($urandom);
        apply_cfg(c);
        send_point(random_point());
        c = scheme_cfg(SCH_SPARE_LAST);
        c.default_rgb = 24'h00_0000;
        apply_cfg(c);
        send_point(random_point());
    endtask

    function automatic t_map_cfg random_cfg(input int phase);
        t_map_cfg    c;
        logic [31:0] lo;
        if (phase == 0) begin
            // all registers at their low end
            c = '{1'b0, 1'b0, 1'b0, pcm_pkg::SCH_OWN, 32'sh8000_0000, 32'sh8000_0000,
                  24'h0};
        end else if (phase == 1) begin
            // all registers at their high end
            c = '{1'b1, 1'b1, 1'b1, SCH_SPARE_LAST, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  24'hFF_FFFF};
        end else begin
            c.use_point_color  = 1'($urandom_range(0, 1));
            c.cloud_has_colors = ($urandom_range(0, 2) == 0);
            c.use_color_map    = ($urandom_range(0, 3) != 0);
            c.scheme = ($urandom_range(0, 1) == 0) ? pcm_pkg::SCH_HEIGHT :
                                                     3'($urandom_range(0, 7));
            c.default_rgb      = 24'($urandom);
            lo = $urandom;
            case ($urandom_range(0, 5))
                0: begin
                    c.height_min = $urandom;
                    c.height_max = $urandom;
                end
                1: begin
                    c.height_min = lo;
                    c.height_max = lo + $urandom_range(1, 1000);
                end
                2: begin
                    c.height_min = lo;
                    c.height_max = lo;
                end
                3: begin
                    c.height_min = lo;
                    c.height_max = lo - $urandom_range(1, 1 << 20);
                end
                4: begin
                    c.height_min = 32'sh8000_0000;
                    c.height_max = 32'sh7FFF_FFFF;
                end
                default: begin
                    c.height_min = 32'($signed(16'($urandom)));
                    c.height_max = c.height_min + $urandom_range(1, 1 << 24);
                end
            endcase
        end
        return c;
    endfunction

    // Mostly heights around the bounds, normals in range and class codes 0 to 20;
    // the rest full-width noise.
    function automatic t_point random_point_for(input t_map_cfg c);
        t_point      p;
        logic [63:0] span;
        logic [63:0] pick;
        p = random_point();
        span = 64'(c.height_max) - 64'(c.height_min);
        if ($signed(span) > 0 && $urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 7) == 0)
                pick = (span * $urandom_range(0, 4)) / 4 + span / 8;
            else
                pick = {$urandom, $urandom} % (span + span / 4 + 1);
            p.height = 32'(64'(c.height_min) + pick - span / 8);
        end
        if ($urandom_range(0, 3) != 0) begin
            p.normal_x = 16'($urandom_range(0, 32768)) - 16'sd16384;
            p.normal_y = 16'($urandom_range(0, 32768)) - 16'sd16384;
            p.normal_z = 16'($urandom_range(0, 32768)) - 16'sd16384;
        end
        if ($urandom_range(0, 3) != 0)
            p.class_code = 8'($urandom_range(0, 20));
        return p;
    endfunction

    task automatic test_random_mix();
        t_map_cfg c;
        for (int phase = 0; phase < 17; phase++) begin
            c = random_cfg(phase);
            apply_cfg(c);
            steady_feed = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 100; k++)
                send_point(random_point_for(c));
        end
        steady_feed = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_height     = '0;
        i_intensity  = '0;
        i_class_code = '0;
        i_normal_x   = '0;
        i_normal_y   = '0;
        i_normal_z   = '0;
        i_own_red    = '0;
        i_own_green  = '0;
        i_own_blue   = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        cycle_count  = 0;
        n_points     = 0;
        n_colors     = 0;
        n_settings   = 0;
        n_mismatch   = 0;
        steady_feed  = 1'b0;
        map_cfg = '{1'b1, 1'b0, 1'b0, pcm_pkg::SCH_OWN, 32'sd0, 32'sd0,
                    pcm_pkg::DEFAULT_RGB_RST};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_own_color();
        test_height_ramp();
        test_intensity_gray();
        test_class_table();
        test_normal_map();
        test_default_color();
        test_random_mix();

        settle();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d points through %0d register settings, %0d colors checked",
                 n_points, n_settings, n_colors);
        $display("Schemes: own, height ramp, gray, class, normal, spare; %0d bad",
                 n_mismatch + pending_colors.size());
        if (n_mismatch == 0 && pending_colors.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
